[rtl/asd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg
// shared widths, register indexes and reset values of the step detector
// ----------------------------------------------------------------------------
package asd_pkg;

    // default sample width taken from each axis field
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed datapath widths
    localparam int SUM_W   = 32;          // sum of squares
    localparam int ROOT_W  = 16;          // floor square root
    localparam int REM_W   = ROOT_W + 2;  // partial remainder of the root
    localparam int TIME_W  = 32;          // millisecond timestamp
    localparam int COUNT_W = 32;          // running step count

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 1'd1;

    localparam logic [CFG_W-1:0] MAG_THRESHOLD_RST = 16'd7000;
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST  = 16'd400;

endpackage : asd_pkg
`default_nettype wire

[rtl/asd_sumsq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asd_sumsq
// sum of squares of three axis samples with one shared multiplier
// ----------------------------------------------------------------------------
module asd_sumsq #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [SAMPLE_BITS-1:0]        sample_x,
    input  wire logic [SAMPLE_BITS-1:0]        sample_y,
    input  wire logic [SAMPLE_BITS-1:0]        sample_z,
    output logic                               done,
    output logic [asd_pkg::SUM_W-1:0]          sum
);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic                         busy_reg,  busy_next;
    logic                         done_reg,  done_next;
    logic [1:0]                   axis_reg,  axis_next;
    logic [asd_pkg::SUM_W-1:0]    acc_reg,   acc_next;

    logic [SAMPLE_BITS-1:0]       sel_sample;
    logic [SAMPLE_BITS-1:0]       abs_sample;
    logic [2*SAMPLE_BITS-1:0]     square;

    // axis select, magnitude and square
    always_comb begin
        unique case (axis_reg)
            AXIS_X:  sel_sample = sample_x;
            AXIS_Y:  sel_sample = sample_y;
            AXIS_Z:  sel_sample = sample_z;
            default: sel_sample = sample_z;
        endcase
        abs_sample = sel_sample[SAMPLE_BITS-1] ? (~sel_sample + SAMPLE_BITS'(1)) : sel_sample;
        square     = abs_sample * abs_sample;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        axis_next = axis_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            axis_next = AXIS_X;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + asd_pkg::SUM_W'(square);
            if (axis_reg == AXIS_Z) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                axis_next = axis_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            axis_reg <= AXIS_X;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            axis_reg <= axis_next;
        end
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule : asd_sumsq
`default_nettype wire

[rtl/asd_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asd_sqrt
// floor square root, one result bit per cycle (restoring digit recurrence)
// ----------------------------------------------------------------------------
module asd_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [asd_pkg::SUM_W-1:0]     radicand,
    output logic                               done,
    output logic [asd_pkg::ROOT_W-1:0]         root
);

    localparam int CNT_W = $clog2(asd_pkg::ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(asd_pkg::ROOT_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg,  cnt_next;
    logic [asd_pkg::SUM_W-1:0]     op_reg,   op_next;
    logic [asd_pkg::REM_W-1:0]     rem_reg,  rem_next;
    logic [asd_pkg::ROOT_W-1:0]    root_reg, root_next;

    logic [asd_pkg::REM_W-1:0]     rem_shift;
    logic [asd_pkg::REM_W-1:0]     trial;

    // bring down the next two radicand bits and try a one digit
    assign rem_shift = {rem_reg[asd_pkg::REM_W-3:0], op_reg[asd_pkg::SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            op_next = {op_reg[asd_pkg::SUM_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[asd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[asd_pkg::ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule : asd_sqrt
`default_nettype wire

[rtl/accel_step_detector_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// accel_step_detector_top
// step detector on three-axis acceleration magnitude
// ----------------------------------------------------------------------------
// Each accepted item (x, y, z sample and a millisecond tick) yields exactly one
// result item: a flag that says whether this sample counted a step and the
// running step count. The magnitude is the floor square root of x*x+y*y+z*z,
// where only the low SAMPLE_BITS bits of each axis are used, sign-extended.
// A step counts when the magnitude moved by more than magnitude_threshold
// since the previous sample and more than min_step_interval ms (modulo 2^32)
// went by since the last counted step; the first sample after reset only
// loads the previous magnitude. An item passes from acceptance to its
// result through the shared squaring multiplier, the start of the root
// unit, the bit-per-cycle root unit, the hand-over of the root to the
// sequencer and the decision. The input is not ready while an item is in
// flight; it is ready again the cycle after the result is written, even
// while that result waits on m_ready. If the earlier result is still waiting
// when the next item finishes, that item holds in the decision state until
// the result is taken.
// Configuration writes are taken at any edge with cfg_wr_en high and should
// only be issued while the block is idle; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module accel_step_detector_top #(
    parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [asd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [asd_pkg::CFG_W-1:0]        cfg_data,

    // sample items in
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [15:0]               s_accel_x,
    input  wire logic signed [15:0]               s_accel_y,
    input  wire logic signed [15:0]               s_accel_z,
    input  wire logic [asd_pkg::TIME_W-1:0]       s_time_ms,

    // result items out
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_step_seen,
    output logic [asd_pkg::COUNT_W-1:0]           m_total_steps
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;   // ready for an item
    localparam logic [1:0] ST_SQ     = 2'd1;   // squaring and summing
    localparam logic [1:0] ST_ROOT   = 2'd2;   // root iterations
    localparam logic [1:0] ST_DECIDE = 2'd3;   // step test and result write

    logic [1:0]                     state_reg, state_next;

    // configuration registers
    logic [asd_pkg::CFG_W-1:0]      thr_reg, thr_next;
    logic [asd_pkg::CFG_W-1:0]      ivl_reg, ivl_next;

    // captured item
    logic [SAMPLE_BITS-1:0]         x_reg, y_reg, z_reg;
    logic [asd_pkg::TIME_W-1:0]     time_reg;

    // detector state
    logic [asd_pkg::ROOT_W-1:0]     prev_mag_reg,   prev_mag_next;
    logic [asd_pkg::TIME_W-1:0]     last_time_reg,  last_time_next;
    logic [asd_pkg::COUNT_W-1:0]    step_total_reg, step_total_next;
    logic                           primed_reg,     primed_next;

    // output register
    logic                           m_valid_reg,  m_valid_next;
    logic                           m_seen_reg,   m_seen_next;
    logic [asd_pkg::COUNT_W-1:0]    m_total_reg,  m_total_next;

    logic                           accept;
    logic                           sq_done;
    logic [asd_pkg::SUM_W-1:0]      sq_sum;
    logic                           rt_done;
    logic [asd_pkg::ROOT_W-1:0]     rt_root;

    logic [asd_pkg::ROOT_W-1:0]     mag_diff;
    logic [asd_pkg::TIME_W-1:0]     elapsed;
    logic                           step_hit;
    logic                           out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // shared squaring multiplier, one axis per cycle
    asd_sumsq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sumsq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .sample_x (x_reg),
        .sample_y (y_reg),
        .sample_z (z_reg),
        .done     (sq_done),
        .sum      (sq_sum)
    );

    // root unit, one result bit per cycle
    asd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_done),
        .radicand (sq_sum),
        .done     (rt_done),
        .root     (rt_root)
    );

    // step test on the finished magnitude
    assign mag_diff = (rt_root >= prev_mag_reg) ? (rt_root - prev_mag_reg)
                                                : (prev_mag_reg - rt_root);
    assign elapsed  = time_reg - last_time_reg;
    assign step_hit = primed_reg
                      && (mag_diff > asd_pkg::ROOT_W'(thr_reg))
                      && (elapsed > asd_pkg::TIME_W'(ivl_reg));

    // a result may be written once the previous one is gone or leaving
    assign out_free = !m_valid_reg || m_ready;

    // configuration writes
    always_comb begin
        thr_next = thr_reg;
        ivl_next = ivl_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                asd_pkg::CFG_MAG_THRESHOLD: thr_next = cfg_data;
                asd_pkg::CFG_MIN_INTERVAL:  ivl_next = cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and detector state
    always_comb begin
        state_next      = state_reg;
        prev_mag_next   = prev_mag_reg;
        last_time_next  = last_time_reg;
        step_total_next = step_total_reg;
        primed_next     = primed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_seen_next     = m_seen_reg;
        m_total_next    = m_total_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (sq_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (rt_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // hold here until the output register can take the result
                if (out_free) begin
                    state_next    = ST_IDLE;
                    prev_mag_next = rt_root;
                    primed_next   = 1'b1;
                    if (step_hit) begin
                        step_total_next = step_total_reg + asd_pkg::COUNT_W'(1);
                        last_time_next  = time_reg;
                    end
                    m_valid_next = 1'b1;
                    m_seen_next  = step_hit;
                    m_total_next = step_hit ? (step_total_reg + asd_pkg::COUNT_W'(1))
                                            : step_total_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            thr_reg        <= asd_pkg::MAG_THRESHOLD_RST;
            ivl_reg        <= asd_pkg::MIN_INTERVAL_RST;
            prev_mag_reg   <= '0;
            last_time_reg  <= '0;
            step_total_reg <= '0;
            primed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            ivl_reg        <= ivl_next;
            prev_mag_reg   <= prev_mag_next;
            last_time_reg  <= last_time_next;
            step_total_reg <= step_total_next;
            primed_reg     <= primed_next;
            m_valid_reg    <= m_valid_next;
        end
        m_seen_reg  <= m_seen_next;
        m_total_reg <= m_total_next;
        // capture the item payload on acceptance
        if (accept) begin
            x_reg    <= s_accel_x[SAMPLE_BITS-1:0];
            y_reg    <= s_accel_y[SAMPLE_BITS-1:0];
            z_reg    <= s_accel_z[SAMPLE_BITS-1:0];
            time_reg <= s_time_ms;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_step_seen   = m_seen_reg;
    assign m_total_steps = m_total_reg;

    // a new result only ever comes out of the decision state
    a_result_from_decide : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DECIDE)
        else $error("result item raised outside the decision state");

    // the root unit only finishes while the sequencer waits on it
    a_root_done_in_root : assert property (@(posedge aclk) disable iff (!aresetn)
        rt_done |-> state_reg == ST_ROOT)
        else $error("root unit finished outside the root state");

    // the first sample after reset never counts a step
    a_first_no_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && !primed_reg) |-> !step_hit)
        else $error("step counted on the first sample");

    // a counted step advances the total by exactly one
    a_step_increments : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && out_free && step_hit)
        |=> step_total_reg == $past(step_total_reg) + asd_pkg::COUNT_W'(1))
        else $error("step total did not advance by one");

endmodule : accel_step_detector_top
`default_nettype wire
